@@ design/nysiis_pkg.sv @@
// NYSIIS encoder package: sizes, character constants, sequencer states and a vowel test.
// No dependencies.
`default_nettype none
package nysiis_pkg;
  localparam int unsigned MaxLenDefault = 32;

  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChD = 8'h44;
  localparam logic [7:0] ChE = 8'h45;
  localparam logic [7:0] ChF = 8'h46;
  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChH = 8'h48;
  localparam logic [7:0] ChI = 8'h49;
  localparam logic [7:0] ChK = 8'h4B;
  localparam logic [7:0] ChM = 8'h4D;
  localparam logic [7:0] ChN = 8'h4E;
  localparam logic [7:0] ChO = 8'h4F;
  localparam logic [7:0] ChP = 8'h50;
  localparam logic [7:0] ChQ = 8'h51;
  localparam logic [7:0] ChR = 8'h52;
  localparam logic [7:0] ChS = 8'h53;
  localparam logic [7:0] ChT = 8'h54;
  localparam logic [7:0] ChU = 8'h55;
  localparam logic [7:0] ChV = 8'h56;
  localparam logic [7:0] ChW = 8'h57;
  localparam logic [7:0] ChY = 8'h59;
  localparam logic [7:0] ChZ = 8'h5A;
  localparam logic [7:0] ChSp = 8'h20;

  typedef enum logic [3:0] {
    ST_LOAD,   // taking bytes
    ST_PRE0,   // read name[0..2] for prefix rules
    ST_PRE1,
    ST_PRE2,
    ST_SUF1,   // read name[n-2], name[n-1]
    ST_SUF2,
    ST_COPY,   // copy to work window
    ST_WALK,   // translate one position per pass
    ST_TRIM,   // trailing rules
    ST_EMIT    // one code char per item
  } state_e;

  function automatic logic is_vowel(input logic [7:0] c);
    return (c == ChA) || (c == ChE) || (c == ChI) || (c == ChO) || (c == ChU);
  endfunction
endpackage
`default_nettype wire

@@ design/nysiis_if.sv @@
// Valid/ready stream interfaces for the NYSIIS encoder.
// Depends on nothing.
`default_nettype none
interface nysiis_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       no_byte;
  logic       end_of_name;
  modport source (output valid, name_byte, no_byte, end_of_name, input ready);
  modport sink   (input valid, name_byte, no_byte, end_of_name, output ready);
endinterface

interface nysiis_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       code_empty;
  logic       truncated;
  logic       last_of_code;
  modport source (output valid, code_byte, code_empty, truncated, last_of_code,
                  input ready);
  modport sink   (input valid, code_byte, code_empty, truncated, last_of_code,
                  output ready);
endinterface
`default_nettype wire

@@ design/nysiis_phonetic_encoder.sv @@
// NYSIIS phonetic encoder top level.
// Uses nysiis_pkg and the stream interfaces in nysiis_if.sv.
//
// Usage: a name arrives on in_if one byte per item; end_of_name marks the
// last item (no_byte set on it means it carries no character). Bytes load
// at one per cycle. After the last item the block stops taking items and a
// sequencer runs over the stored name: prefix/suffix reads in ST_PRE0 to
// ST_SUF2, then one store read per cycle into a work copy, then one walk
// step per cycle (each step reads a fixed window of the work copy and
// appends 0-2 characters to the code store), then a trim step. Codes emit
// on out_if one character per item from a registered output stage; a stall
// on out_if holds the emitter. Bytes beyond MAX_LEN are dropped and flagged
// as truncated. Reset returns to loading with an empty name. An empty code
// gives one item with code_empty set.
`default_nettype none
module nysiis_phonetic_encoder
  import nysiis_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  nysiis_in_if.sink   in_if,
  nysiis_out_if.source out_if
);
  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned CAP = MAX_LEN + 2;
  localparam int unsigned CW = $clog2(CAP + 1);
  localparam int unsigned CAW = $clog2(CAP);

  state_e state_q, state_d;

  logic [7:0]    name_mem [MAX_LEN];
  logic [7:0]    work_q   [MAX_LEN];
  logic [7:0]    code_mem [CAP];
  logic [LW-1:0] len_q;
  logic          ovf_q;
  logic [LW-1:0] idx_q;   // copy / walk position
  logic [CW-1:0] clen_q;  // code length
  logic [7:0]    last_q;  // last code character
  logic [7:0]    prev_q;  // character before last code char
  logic [7:0]    rd_q;    // registered store read
  logic [7:0]    p0_q, p1_q, p2_q;
  logic [CW-1:0] eidx_q;
  logic          ovalid_q;
  logic          sfx_hit_q;
  logic [7:0]    sfx_rep_q;

  // byte fold and acceptance
  wire in_fire = in_if.valid && in_if.ready;
  wire has_byte = !in_if.no_byte && (in_if.name_byte != 8'd0);
  wire [7:0] folded = (in_if.name_byte >= 8'h61 && in_if.name_byte <= 8'h7A)
                      ? in_if.name_byte - 8'd32 : in_if.name_byte;
  assign in_if.ready = (state_q == ST_LOAD);

  // store read address for the sequencer
  logic [AW-1:0] raddr;
  always_comb begin
    unique case (state_q)
      ST_PRE0: raddr = AW'(0);
      ST_PRE1: raddr = AW'(1);
      ST_PRE2: raddr = AW'(2 % MAX_LEN);
      ST_SUF1: raddr = AW'(len_q - LW'(2));
      ST_SUF2: raddr = AW'(len_q - LW'(1));
      default: raddr = idx_q[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && has_byte && len_q < LW'(MAX_LEN)) name_mem[len_q[AW-1:0]] <= folded;
    rd_q <= name_mem[raddr];
  end

  // work window around the walk position
  wire [LW:0] ip1 = {1'b0, idx_q} + 1'b1;
  wire [LW:0] ip2 = {1'b0, idx_q} + 2'd2;
  wire [7:0] w_c  = work_q[idx_q[AW-1:0]];
  wire [7:0] w_pv = work_q[AW'(idx_q - 1'b1)];
  wire [7:0] w_n1 = (ip1 < {1'b0, len_q}) ? work_q[ip1[AW-1:0]] : 8'd0;
  wire [7:0] w_n2 = (ip2 < {1'b0, len_q}) ? work_q[ip2[AW-1:0]] : 8'd0;

  // one walk step: translated chars and skip count
  logic [1:0] nput;
  logic       raw;
  logic [7:0] ca, cb;
  logic [1:0] skip;
  always_comb begin
    nput = 2'd1; raw = 1'b0; ca = w_c; cb = 8'd0; skip = 2'd0;
    priority if (w_c == ChE && w_n1 == ChV) begin
      nput = 2'd2; raw = 1'b1; ca = ChA; cb = ChF; skip = 2'd1;
    end else if (is_vowel(w_c)) begin
      ca = ChA;
    end else if (w_c == ChQ) begin
      ca = ChG;
    end else if (w_c == ChZ) begin
      ca = ChS;
    end else if (w_c == ChM) begin
      ca = ChN;
    end else if (w_c == ChK) begin
      ca = (w_n1 == ChN) ? ChN : ChC;
    end else if (w_c == ChS && w_n1 == ChC && w_n2 == ChH) begin
      nput = 2'd2; raw = 1'b1; ca = ChS; cb = ChS; skip = 2'd2;
    end else if (w_c == ChP && w_n1 == ChH) begin
      raw = 1'b1; ca = ChF; skip = 2'd1;
    end else if (w_c == ChH) begin
      if (!is_vowel(w_n1) || !is_vowel(w_pv)) ca = is_vowel(w_pv) ? ChA : w_pv;
      else ca = ChH;
    end else if (w_c == ChW) begin
      ca = is_vowel(w_pv) ? w_pv : ChW;
    end else begin
      ca = w_c;
    end
  end

  wire put_a = raw || (clen_q == '0) || (last_q != ca);
  wire room1 = clen_q < CW'(CAP);
  wire room2 = clen_q + CW'(1) < CW'(CAP);
  wire [LW:0] pnext = {1'b0, idx_q} + {{(LW-1){1'b0}}, skip} + 1'b1;
  wire walk_done = ({1'b0, idx_q} >= {1'b0, len_q}) || (w_c == ChSp);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (in_fire && in_if.end_of_name) state_d = ST_PRE0;
      ST_PRE0: state_d = ST_PRE1;
      ST_PRE1: state_d = ST_PRE2;
      ST_PRE2: state_d = ST_SUF1;
      ST_SUF1: state_d = ST_SUF2;
      ST_SUF2: state_d = ST_COPY;
      ST_COPY: if ({1'b0, idx_q} >= {1'b0, len_q}) state_d = ST_WALK;
      ST_WALK: if (walk_done || len_q == '0) state_d = ST_TRIM;
      ST_TRIM: state_d = ST_EMIT;
      ST_EMIT: if (ovalid_q && out_if.ready && out_if.last_of_code) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else state_q <= state_d;
  end

  // prefix rewrites on the first three chars
  logic [7:0] pf0, pf1, pf2;
  always_comb begin
    pf0 = p0_q; pf1 = p1_q; pf2 = p2_q;
    if (p0_q == ChM && len_q > LW'(1) && p1_q == ChA && len_q > LW'(2) && p2_q == ChC)
      pf1 = ChC;
    else if (p0_q == ChK && len_q > LW'(1) && p1_q == ChN) pf0 = ChN;
    else if (p0_q == ChK) pf0 = ChC;
    else if (p0_q == ChP && len_q > LW'(1) && p1_q == ChH) begin
      pf0 = ChF; pf1 = ChF;
    end else if (p0_q == ChS && len_q > LW'(1) && p1_q == ChC && len_q > LW'(2)
                 && p2_q == ChH) begin
      pf1 = ChS; pf2 = ChS;
    end
  end

  logic [7:0] sfa;  // name[n-2] as stored
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_PRE1: p0_q <= rd_q;
      ST_PRE2: p1_q <= rd_q;
      ST_SUF1: begin
        p2_q <= (len_q > LW'(2)) ? rd_q : 8'd0;
        sfa <= 8'd0;
      end
      ST_SUF2: sfa <= rd_q;        // name[n-2] raw
      default: ;
    endcase
  end

  // stage holding prefix-rewritten first three chars
  logic [7:0] q0, q1, q2;
  always_ff @(posedge clk_i) if (state_q == ST_SUF2) begin
    q0 <= pf0; q1 <= pf1; q2 <= pf2;
  end

  // copy: idx_q walks the store; rd_q holds name[idx_q-1]
  wire [LW-1:0] cidx = idx_q - LW'(1);
  logic [7:0]   cval;
  always_comb begin
    cval = rd_q;
    if (cidx == LW'(0)) cval = q0;
    else if (cidx == LW'(1)) cval = q1;
    else if (cidx == LW'(2)) cval = q2;
    if (len_q >= LW'(2)) begin
      if (cidx == len_q - LW'(1) && sfx_hit_q) cval = ChSp;
      else if (cidx == len_q - LW'(2) && sfx_hit_q) cval = sfx_rep_q;
    end
  end

  // suffix decision uses chars at n-2, n-1, prefix-rewritten where they fall in the first three
  logic [7:0] sa, sb;
  always_comb begin
    sa = (len_q - LW'(2) == LW'(0)) ? q0 : (len_q - LW'(2) == LW'(1)) ? q1 :
         (len_q - LW'(2) == LW'(2)) ? q2 : sfa;
    sb = (len_q - LW'(1) == LW'(1)) ? q1 : (len_q - LW'(1) == LW'(2)) ? q2 : rd_q;
  end
  always_ff @(posedge clk_i) if (state_q == ST_SUF2 || state_q == ST_COPY) begin
    if (state_q == ST_COPY && idx_q == '0) begin
      sfx_hit_q <= 1'b0;
      sfx_rep_q <= ChD;
      if (len_q >= LW'(2)) begin
        if (sb == ChE && (sa == ChE || sa == ChI)) begin
          sfx_hit_q <= 1'b1; sfx_rep_q <= ChY;
        end else if (sb == ChT && (sa == ChD || sa == ChR || sa == ChN))
          sfx_hit_q <= 1'b1;
        else if (sb == ChD && (sa == ChR || sa == ChN))
          sfx_hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; ovf_q <= 1'b0; idx_q <= '0; clen_q <= '0;
      eidx_q <= '0; ovalid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_fire && has_byte) begin
            if (len_q < LW'(MAX_LEN)) len_q <= len_q + LW'(1);
            else ovf_q <= 1'b1;
          end
          idx_q <= '0;
        end
        ST_SUF2: idx_q <= '0;
        ST_COPY: begin
          if ({1'b0, idx_q} >= {1'b0, len_q}) begin
            idx_q <= LW'(1);
            clen_q <= (len_q == '0) ? CW'(0) : CW'(1);
          end else idx_q <= idx_q + LW'(1);
        end
        ST_WALK: if (!walk_done && len_q != '0) begin
          if (nput == 2'd2) clen_q <= clen_q + (room2 ? CW'(2) : room1 ? CW'(1) : CW'(0));
          else if (put_a && room1) clen_q <= clen_q + CW'(1);
          idx_q <= (pnext > {1'b0, len_q}) ? len_q : pnext[LW-1:0];
        end
        ST_TRIM: begin
          eidx_q <= '0;
          if (clen_q != '0) begin
            if (last_q == ChS) begin
              if (clen_q >= CW'(2) && prev_q == ChA) clen_q <= clen_q - CW'(2);
              else clen_q <= clen_q - CW'(1);
            end else if (last_q == ChY && clen_q >= CW'(2) && prev_q == ChA)
              clen_q <= clen_q - CW'(1);
            else if (last_q == ChA) clen_q <= clen_q - CW'(1);
          end
        end
        ST_EMIT: begin
          if (ovalid_q && out_if.ready && out_if.last_of_code) begin
            ovalid_q <= 1'b0; len_q <= '0; ovf_q <= 1'b0; idx_q <= '0;
          end else if (!ovalid_q || out_if.ready) begin
            if (eidx_q < clen_q || (clen_q == '0 && eidx_q == '0)) begin
              ovalid_q <= 1'b1;
              eidx_q <= eidx_q + CW'(1);
            end else ovalid_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // work copy and code store writes, last two code chars tracked
  logic [7:0] ochar;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_COPY && idx_q != '0) work_q[cidx[AW-1:0]] <= cval;
    if (state_q == ST_COPY && {1'b0, idx_q} >= {1'b0, len_q}) begin
      code_mem[CAW'(0)] <= (len_q == LW'(1)) ? cval : work_q[AW'(0)];
      last_q <= (len_q == LW'(1)) ? cval : work_q[AW'(0)];
    end
    if (state_q == ST_WALK && !walk_done && len_q != '0) begin
      if (nput == 2'd2) begin
        if (room1) code_mem[clen_q[CAW-1:0]] <= ca;
        if (room2) code_mem[CAW'(clen_q + CW'(1))] <= cb;
        if (room2) begin prev_q <= ca; last_q <= cb; end
        else if (room1) begin prev_q <= last_q; last_q <= ca; end
      end else if (put_a && room1) begin
        code_mem[clen_q[CAW-1:0]] <= ca;
        prev_q <= last_q; last_q <= ca;
      end
    end
    if (state_q == ST_TRIM && last_q == ChY && clen_q >= CW'(2) && prev_q == ChA)
      code_mem[CAW'(clen_q - CW'(2))] <= ChY;
    if (state_q == ST_EMIT && (!ovalid_q || out_if.ready))
      ochar <= (clen_q == '0) ? 8'd0 : code_mem[eidx_q[CAW-1:0]];
    if (state_q == ST_EMIT && (!ovalid_q || out_if.ready))
      out_if.last_of_code <= (clen_q == '0) || (eidx_q + CW'(1) == clen_q);
  end

  assign out_if.valid      = ovalid_q;
  assign out_if.code_byte  = ochar;
  assign out_if.code_empty = (clen_q == '0);
  assign out_if.truncated  = ovf_q;
endmodule
`default_nettype wire

@@ design/nysiis_checker.sv @@
// Port-level checker for the NYSIIS encoder, bound to the top level.
// Depends on the encoder top level that it is bound to.
`default_nettype none
module nysiis_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_ready,
  input wire out_valid, out_ready,
  input wire [7:0] code_byte,
  input wire code_empty, last_of_code
);
  // no input is taken while a code is being delivered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input ready during emit");
  // empty code is a single zero item
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && code_empty) |-> (code_byte == 8'd0 && last_of_code))
    else $error("bad empty code item");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(code_byte)))
    else $error("result dropped under stall");
  // back to loading right after the last code item
  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && last_of_code) |=> in_ready)
    else $error("not ready after last code item");
endmodule

bind nysiis_phonetic_encoder nysiis_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .code_byte(out_if.code_byte), .code_empty(out_if.code_empty),
  .last_of_code(out_if.last_of_code)
);
`default_nettype wire
